// ===== rtl/lfr_pkg.sv =====
package lfr_pkg;

    localparam int DEF_FRAME_CNT = 64;

    // Field widths of the stream words
    localparam int FRAME_W  = 8;
    localparam int VICT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;
    localparam int KIND_W   = 2;

    localparam logic [KIND_W-1:0] K_ACCESS = 2'd0;
    localparam logic [KIND_W-1:0] K_SET    = 2'd1;
    localparam logic [KIND_W-1:0] K_EVICT  = 2'd2;
    localparam logic [KIND_W-1:0] K_REMOVE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PINNED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_APPEND,
        S_DONE
    } t_state;

    // Update request for the tracked and evictable marks and the count
    typedef struct packed {
        logic set_trk;
        logic clr_trk;
        logic wr_evm;
        logic evm_val;
        logic cnt_inc;
        logic cnt_dec;
    } t_mark_cmd;

endpackage

// ===== rtl/lru_frame_replacer_top.sv =====
// Flow: an item that needs no list walk passes S_IDLE, S_DECODE and S_DONE, where its result is registered;
// remove and evict walk the recency list, one entry a cycle through the list RAM read
// port; access of a tracked frame walks the list and then appends the frame in S_APPEND.
// One item at a time: the next is accepted once the result is registered, and S_DONE
// waits while the output register still holds a result that has not been taken.
// Reset (synchronous, active low) clears tracked and evictable marks, count and length.
module lru_frame_replacer_top #(
    parameter int FRAME_CNT = lfr_pkg::DEF_FRAME_CNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [7:0] frame, [8] make_evictable, [15:9] zero
    input  logic [1:0]  i_s_tuser,  // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // [0] victim_valid, [6:1] victim_frame,
                                    // [8:7] status, [15:9] evictable_total
);
    import lfr_pkg::*;

    localparam int IDXW = $clog2(FRAME_CNT);
    localparam int CNTW = $clog2(FRAME_CNT + 1);

    t_state               r_state, n_state;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [FRAME_W-1:0]   r_frame, n_frame;
    logic                 r_mk, n_mk;
    logic [CNTW-1:0]      r_len, n_len;
    logic [CNTW-1:0]      r_issue, n_issue;
    logic                 r_pend, n_pend;
    logic [IDXW-1:0]      r_pidx, n_pidx;
    logic                 r_hit, n_hit;
    logic                 r_push, n_push;
    logic                 r_vv, n_vv;
    logic [IDXW-1:0]      r_victim, n_victim;
    logic [STATUS_W-1:0]  r_status, n_status;

    logic                 r_ov, n_ov;
    logic                 r_o_vv, n_o_vv;
    logic [VICT_W-1:0]    r_o_vf, n_o_vf;
    logic [STATUS_W-1:0]  r_o_st, n_o_st;
    logic [TOTAL_W-1:0]   r_o_tot, n_o_tot;

    logic                 ram_we;
    logic [IDXW-1:0]      ram_waddr;
    logic [IDXW-1:0]      ram_wdata;
    logic                 ram_re;
    logic [IDXW-1:0]      ram_rdata;

    t_mark_cmd            mark_cmd;
    logic [IDXW-1:0]      mark_widx;
    logic                 trk_a, evm_a, evm_b;
    logic [CNTW-1:0]      evict_cnt;

    logic [IDXW-1:0]      f_idx;
    logic                 in_range;
    logic                 scan_match;
    logic [CNTW-1:0]      len_m1;
    logic [FRAME_W-1:0]   victim_ext;
    logic                 old_evm;

    assign f_idx      = r_frame[IDXW-1:0];
    assign in_range   = {1'b0, r_frame} < (FRAME_W + 1)'(FRAME_CNT);
    assign scan_match = (r_kind == K_EVICT) ? evm_b : (ram_rdata == f_idx);
    assign len_m1     = r_len - CNTW'(1);
    assign victim_ext = FRAME_W'(r_victim);
    assign old_evm    = trk_a & evm_a;

    lfr_ram #(
        .WIDTH (IDXW),
        .DEPTH (FRAME_CNT)
    ) u_list (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_issue[IDXW-1:0]),
        .o_rd_data (ram_rdata)
    );

    lfr_marks #(
        .FRAME_CNT (FRAME_CNT)
    ) u_marks (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (mark_cmd),
        .i_wr_idx   (mark_widx),
        .i_rd_a_idx (f_idx),
        .o_trk_a    (trk_a),
        .o_evm_a    (evm_a),
        .i_rd_b_idx (ram_rdata),
        .o_evm_b    (evm_b),
        .o_cnt      (evict_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_frame  <= n_frame;
        r_mk     <= n_mk;
        r_issue  <= n_issue;
        r_pidx   <= n_pidx;
        r_hit    <= n_hit;
        r_push   <= n_push;
        r_vv     <= n_vv;
        r_victim <= n_victim;
        r_status <= n_status;
        r_o_vv   <= n_o_vv;
        r_o_vf   <= n_o_vf;
        r_o_st   <= n_o_st;
        r_o_tot  <= n_o_tot;
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_frame  = r_frame;
        n_mk     = r_mk;
        n_len    = r_len;
        n_issue  = r_issue;
        n_pend   = 1'b0;
        n_pidx   = r_pidx;
        n_hit    = r_hit;
        n_push   = r_push;
        n_vv     = r_vv;
        n_victim = r_victim;
        n_status = r_status;
        n_ov     = r_ov;
        n_o_vv   = r_o_vv;
        n_o_vf   = r_o_vf;
        n_o_st   = r_o_st;
        n_o_tot  = r_o_tot;

        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_len[IDXW-1:0];
        ram_wdata  = f_idx;
        ram_re     = 1'b0;
        mark_cmd   = '0;
        mark_widx  = f_idx;

        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_kind   = i_s_tuser;
                    n_frame  = i_s_tdata[FRAME_W-1:0];
                    n_mk     = i_s_tdata[FRAME_W];
                    n_issue  = '0;
                    n_hit    = 1'b0;
                    n_push   = 1'b0;
                    n_vv     = 1'b0;
                    n_victim = '0;
                    n_status = ST_OK;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                if (r_kind == K_EVICT) begin
                    if (evict_cnt != '0) begin
                        n_state = S_SCAN;
                    end
                end else if (!in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    case (r_kind)
                        K_ACCESS: begin
                            if (trk_a) begin
                                n_push  = 1'b1;
                                n_state = S_SCAN;
                            end else begin
                                mark_cmd.set_trk = 1'b1;
                                mark_cmd.wr_evm  = 1'b1;
                                mark_cmd.evm_val = 1'b0;
                                ram_we = 1'b1;
                                n_len  = r_len + CNTW'(1);
                            end
                        end
                        K_SET: begin
                            if (!trk_a) begin
                                ram_we = 1'b1;
                                n_len  = r_len + CNTW'(1);
                            end
                            mark_cmd.set_trk = 1'b1;
                            mark_cmd.wr_evm  = 1'b1;
                            mark_cmd.evm_val = r_mk;
                            mark_cmd.cnt_inc = r_mk & ~old_evm;
                            mark_cmd.cnt_dec = ~r_mk & old_evm;
                        end
                        K_REMOVE: begin
                            if (trk_a) begin
                                if (!evm_a) begin
                                    n_status = ST_PINNED;
                                end else begin
                                    mark_cmd.clr_trk = 1'b1;
                                    mark_cmd.wr_evm  = 1'b1;
                                    mark_cmd.evm_val = 1'b0;
                                    mark_cmd.cnt_dec = 1'b1;
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one list read a cycle; data returns from the registered RAM read in the next cycle
                ram_re = (r_issue < r_len);
                if (ram_re) begin
                    n_issue = r_issue + CNTW'(1);
                    n_pend  = 1'b1;
                    n_pidx  = r_issue[IDXW-1:0];
                end
                if (r_pend) begin
                    if (!r_hit && scan_match) begin
                        n_hit = 1'b1;
                        if (r_kind == K_EVICT) begin
                            n_vv     = 1'b1;
                            n_victim = ram_rdata;
                            mark_widx        = ram_rdata;
                            mark_cmd.clr_trk = 1'b1;
                            mark_cmd.wr_evm  = 1'b1;
                            mark_cmd.evm_val = 1'b0;
                            mark_cmd.cnt_dec = 1'b1;
                        end
                    end else if (r_hit) begin
                        // close the gap: shift the word down one place
                        ram_we    = 1'b1;
                        ram_waddr = r_pidx - IDXW'(1);
                        ram_wdata = ram_rdata;
                    end
                end
                if (!ram_re && !r_pend) begin
                    n_state = S_DONE;
                    if (r_hit) begin
                        if (r_push) begin
                            n_state = S_APPEND;
                        end else begin
                            n_len = len_m1;
                        end
                    end
                end
            end
            S_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = len_m1[IDXW-1:0];
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_m_tready) begin
                    n_ov    = 1'b1;
                    n_o_vv  = r_vv;
                    n_o_vf  = victim_ext[VICT_W-1:0];
                    n_o_st  = r_status;
                    n_o_tot = TOTAL_W'(evict_cnt);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_o_tot, r_o_st, r_o_vf, r_o_vv};

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CNTW'(FRAME_CNT))
        else $error("list length above frame count");

    a_cnt_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        evict_cnt <= r_len)
        else $error("evictable count above list length");

    // evict only walks the list when some frame is unpinned, so it must find one
    a_evict_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_kind == K_EVICT && !r_pend && r_issue == r_len)
        |-> r_hit)
        else $error("evict walk ended without a victim");

    a_victim_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_vv) |-> (r_o_st == ST_OK))
        else $error("victim reported with error status");
`endif

endmodule

// ===== rtl/lfr_ram.sv =====
module lfr_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lfr_marks.sv =====
module lfr_marks #(
    parameter int FRAME_CNT = lfr_pkg::DEF_FRAME_CNT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lfr_pkg::t_mark_cmd                i_cmd,
    input  logic [$clog2(FRAME_CNT)-1:0]      i_wr_idx,
    input  logic [$clog2(FRAME_CNT)-1:0]      i_rd_a_idx,
    output logic                              o_trk_a,
    output logic                              o_evm_a,
    input  logic [$clog2(FRAME_CNT)-1:0]      i_rd_b_idx,
    output logic                              o_evm_b,
    output logic [$clog2(FRAME_CNT+1)-1:0]    o_cnt
);
    import lfr_pkg::*;

    localparam int CNTW = $clog2(FRAME_CNT + 1);

    logic [FRAME_CNT-1:0] r_trk;
    logic [FRAME_CNT-1:0] r_evm;
    logic [CNTW-1:0]      r_cnt;
    logic [CNTW-1:0]      n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.cnt_inc) begin
            n_cnt = r_cnt + CNTW'(1);
        end else if (i_cmd.cnt_dec && (r_cnt != '0)) begin
            n_cnt = r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk <= '0;
            r_evm <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.set_trk) begin
                r_trk[i_wr_idx] <= 1'b1;
            end else if (i_cmd.clr_trk) begin
                r_trk[i_wr_idx] <= 1'b0;
            end
            if (i_cmd.wr_evm) begin
                r_evm[i_wr_idx] <= i_cmd.evm_val;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_trk_a = r_trk[i_rd_a_idx];
    assign o_evm_a = r_evm[i_rd_a_idx];
    assign o_evm_b = r_evm[i_rd_b_idx];
    assign o_cnt   = r_cnt;

`ifndef SYNTHESIS
    // an unpinned frame is always a tracked one
    a_evm_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_evm & ~r_trk) == '0)
        else $error("evictable mark set on untracked frame");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(FRAME_CNT))
        else $error("evictable count above frame count");

    a_cnt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_evm) == int'(r_cnt))
        else $error("evictable count disagrees with marks");
`endif

endmodule
